>>> rtl/uer_pkg.sv
// Shared types and constants for the UART echo ring buffer block.
`timescale 1ns / 1ps

package uer_pkg;

    // Operation codes carried on the input tuser field.
    typedef enum logic [1:0] {
        OP_LINE_RX  = 2'd0,
        OP_HOST_WR  = 2'd1,
        OP_TX_READY = 2'd2,
        OP_HOST_RD  = 2'd3
    } t_op;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Width of the fill counts reported with each result.
    localparam int FILL_W = 10;

    // Width of the packed result word on the output tdata.
    localparam int RES_W = 40;

    // Command from the sequencer to one ring FIFO.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } t_fifo_cmd;

endpackage

>>> rtl/uer_fifo.sv
// One byte ring FIFO: storage memory with head pointer and entry count.
`timescale 1ns / 1ps

module uer_fifo
    import uer_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_fifo_cmd     i_cmd,
    output logic [CW-1:0] o_count,
    output logic [7:0]    o_rdata
);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;

    logic [CW:0]   w_sum;
    logic [CW:0]   w_sum_wrap;
    logic [AW-1:0] w_wr_idx;
    logic [AW:0]   w_head_inc;

    // Tail slot is head plus count, folded back once into the ring.
    always_comb begin
        w_sum      = (CW+1)'(r_head) + (CW+1)'(r_count);
        w_sum_wrap = (w_sum >= (CW+1)'(DEPTH)) ? (w_sum - (CW+1)'(DEPTH)) : w_sum;
        w_wr_idx   = w_sum_wrap[AW-1:0];
        w_head_inc = (AW+1)'(r_head) + (AW+1)'(1);
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
            n_head  = (w_head_inc == (AW+1)'(DEPTH)) ? '0 : w_head_inc[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[w_wr_idx] <= i_cmd.wdata;
        end
        if (i_cmd.pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_count = r_count;
    assign o_rdata = r_rdata;

endmodule

>>> rtl/uart_echo_ring_buffers.sv
// Top level: operation sequencer, two ring FIFOs and the result register.
// Sequence: a plain byte goes from IDLE to DONE; a newline echo that needs a
// second push passes through ECHO_LF, and a pop waits in READ for memory read data.
// A new item is taken only in IDLE, so no item is accepted before the last
// one's result has been moved from DONE into the output register.
// Reset: synchronous, active low; both FIFOs come up empty, no result pending.
`timescale 1ns / 1ps

module uart_echo_ring_buffers
    import uer_pkg::*;
#(
    parameter int FIFO_DEPTH = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,  // [7:0] data_byte
    input  logic [1:0]       s_axis_tuser,  // [1:0] operation
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // m_axis_tdata from bit 0 up: line_tx_valid, line_tx_byte[8], read_valid,
    // read_byte[8], write_refused, rx_dropped, tx_fill[10], rx_fill[10].
    output logic [RES_W-1:0] m_axis_tdata
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    // The sequencer: an item is taken in IDLE. A newline echo needs a second
    // transmit push, and a pop waits in READ for the registered memory read data. The
    // result is staged in DONE until the output register is free, so the
    // next item can be accepted while a result still waits downstream.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ECHO_LF,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;
    t_op    r_op;
    logic   r_tx_valid;
    logic   r_rd_valid;
    logic   r_refused;
    logic   r_dropped;
    logic [7:0] r_byte;
    logic             r_m_tvalid;
    logic [RES_W-1:0] r_m_tdata;

    t_fifo_cmd     w_tx_cmd;
    t_fifo_cmd     w_rx_cmd;
    logic [CW-1:0] w_tx_count;
    logic [CW-1:0] w_rx_count;
    logic [7:0]    w_tx_rdata;
    logic [7:0]    w_rx_rdata;

    logic   w_accept;
    t_op    w_op;
    logic   w_nl;
    logic   w_tx_room;
    logic   w_tx_two;
    logic   w_rx_room;
    logic   w_wr_fits;
    logic   w_out_free;
    logic [RES_W-1:0] w_result;

    // No transfer is taken while reset is held.
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser);
    assign w_nl          = (s_axis_tdata == CH_CR) || (s_axis_tdata == CH_LF);
    assign w_tx_room     = (w_tx_count < CW'(FIFO_DEPTH));
    assign w_tx_two      = ((CW+1)'(w_tx_count) + (CW+1)'(2)) <= (CW+1)'(FIFO_DEPTH);
    assign w_rx_room     = (w_rx_count < CW'(FIFO_DEPTH));
    // A host LF becomes CR LF, so it is taken only with two free slots.
    assign w_wr_fits     = (s_axis_tdata == CH_LF) ? w_tx_two : w_tx_room;
    assign w_out_free    = !r_m_tvalid || m_axis_tready;

    // FIFO commands. Line bytes echo CR or LF as CR first, then LF in the
    // following cycle; the receive side stores either as LF.
    always_comb begin
        w_tx_cmd = '0;
        w_rx_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_LINE_RX: begin
                            w_tx_cmd.push  = w_tx_room;
                            w_tx_cmd.wdata = w_nl ? CH_CR : s_axis_tdata;
                            w_rx_cmd.push  = w_rx_room;
                            w_rx_cmd.wdata = w_nl ? CH_LF : s_axis_tdata;
                        end
                        OP_HOST_WR: begin
                            w_tx_cmd.push  = w_wr_fits;
                            w_tx_cmd.wdata = (s_axis_tdata == CH_LF) ? CH_CR : s_axis_tdata;
                        end
                        OP_TX_READY: begin
                            w_tx_cmd.pop = (w_tx_count != '0);
                        end
                        OP_HOST_RD: begin
                            w_rx_cmd.pop = (w_rx_count != '0);
                        end
                        default: begin
                            w_tx_cmd = '0;
                        end
                    endcase
                end
            end
            S_ECHO_LF: begin
                // Echo bytes that do not fit are dropped silently.
                w_tx_cmd.push  = w_tx_room;
                w_tx_cmd.wdata = CH_LF;
            end
            default: begin
                w_tx_cmd = '0;
            end
        endcase
    end

    uer_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_tx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_tx_cmd),
        .o_count (w_tx_count),
        .o_rdata (w_tx_rdata)
    );

    uer_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_rx_cmd),
        .o_count (w_rx_count),
        .o_rdata (w_rx_rdata)
    );

    // Result word; counts are taken after all pushes and pops of the item.
    assign w_result = {FILL_W'(w_rx_count),
                       FILL_W'(w_tx_count),
                       r_dropped,
                       r_refused,
                       (r_rd_valid ? r_byte : 8'd0),
                       r_rd_valid,
                       (r_tx_valid ? r_byte : 8'd0),
                       r_tx_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tx_valid <= 1'b0;
            r_rd_valid <= 1'b0;
            r_refused  <= 1'b0;
            r_dropped  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            // The output register is loaded from DONE, otherwise it empties
            // once its transfer completes.
            if ((r_state == S_DONE) && w_out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op       <= w_op;
                        r_byte     <= 8'd0;
                        r_tx_valid <= w_tx_cmd.pop;
                        r_rd_valid <= w_rx_cmd.pop;
                        r_refused  <= (w_op == OP_HOST_WR) && !w_wr_fits;
                        r_dropped  <= (w_op == OP_LINE_RX) && !w_rx_room;
                        if (w_tx_cmd.pop || w_rx_cmd.pop) begin
                            r_state <= S_READ;
                        end else if (w_nl && (w_op == OP_LINE_RX)) begin
                            r_state <= S_ECHO_LF;
                        end else if ((w_op == OP_HOST_WR) && w_wr_fits
                                     && (s_axis_tdata == CH_LF)) begin
                            r_state <= S_ECHO_LF;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_ECHO_LF: begin
                    r_state <= S_DONE;
                end
                S_READ: begin
                    r_byte  <= (r_op == OP_TX_READY) ? w_tx_rdata : w_rx_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_m_tdata  <= w_result;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

endmodule
